### hw/rtl/aarm_pkg.sv
// Shared constants, types and helper functions of the axis-angle rotation matrix core.
`default_nettype none
package aarm_pkg;

	localparam int ENTRY_FRAC_BITS = 14;
	localparam int TRIG_STAGES     = 16;

	localparam int DIV_W       = 32;
	localparam int DIV_STAGES  = DIV_W;
	localparam int SQRT_STAGES = 32;
	localparam int TRIG_W      = 34;
	localparam int ACC_W       = 70;
	localparam int ROUND_SH    = 60 - ENTRY_FRAC_BITS;

	localparam int AXIS_DONE  = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1;
	localparam int TRIG_DONE  = 5 + TRIG_STAGES + 1;
	localparam int CS_DELAY   = AXIS_DONE - TRIG_DONE;
	localparam int PIPE_DEPTH = AXIS_DONE + 3;

	localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [TRIG_W-1:0] ONE_Q30      = 34'sd1073741824;
	localparam logic signed [ACC_W-1:0]  ROUND_HALF   = ACC_W'(1) <<< (ROUND_SH - 1);

	localparam logic signed [17:0] TURN_UNITS     = 18'sd23040;
	localparam logic signed [17:0] TWO_TURN_UNITS = 18'sd46080;
	localparam logic signed [17:0] EIGHTH_UNITS   = 18'sd2880;
	localparam logic [14:0] QUARTER_1 = 15'd5760;
	localparam logic [14:0] QUARTER_2 = 15'd11520;
	localparam logic [14:0] QUARTER_3 = 15'd17280;

	// pi in Q30 divided by 11520 is split into an integer part and a remainder.
	localparam logic [18:0] PI_DIV_INT  = 19'd292817;
	localparam logic [12:0] PI_DIV_REM  = 13'd7586;
	localparam logic [24:0] HALF_11520  = 25'd5760;
	localparam logic [18:0] RECIP_45    = 19'd372828;

	typedef struct packed {
		logic [2:0][15:0] a;
		logic [5:0][31:0] pr;
		logic [31:0]      len;
		logic             zero;
	} axis_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		axis_t       ax;
	} sqrt_t;

	function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
		logic signed [TRIG_W-1:0] v;
		unique case (i)
			0: v = 34'sd843314857;
			1: v = 34'sd497837829;
			2: v = 34'sd263043837;
			3: v = 34'sd133525159;
			4: v = 34'sd67021687;
			5: v = 34'sd33543516;
			6: v = 34'sd16775851;
			7: v = 34'sd8388437;
			8: v = 34'sd4194283;
			9: v = 34'sd2097149;
			10: v = 34'sd1048576;
			11: v = 34'sd524288;
			12: v = 34'sd262144;
			default: v = (i <= 30) ? (ONE_Q30 >>> i) : '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sat_entry(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] sh;
		logic signed [15:0] r;
		sh = v >>> ROUND_SH;
		if (sh > ACC_W'(32767)) begin
			r = 16'sh7FFF;
		end else if (sh < -ACC_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = sh[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/aarm_if.sv
// Handshake channels for the request and result words of the rotation matrix core.
`default_nettype none
interface aarm_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [15:0] angle_deg;

	modport source (output valid, output axis_x, output axis_y, output axis_z,
		output angle_deg, input ready);
	modport sink (input valid, input axis_x, input axis_y, input axis_z,
		input angle_deg, output ready);
endinterface

interface aarm_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] m00;
	logic signed [15:0] m01;
	logic signed [15:0] m02;
	logic signed [15:0] m10;
	logic signed [15:0] m11;
	logic signed [15:0] m12;
	logic signed [15:0] m20;
	logic signed [15:0] m21;
	logic signed [15:0] m22;
	logic zero_axis;

	modport source (output valid, output m00, output m01, output m02, output m10,
		output m11, output m12, output m20, output m21, output m22,
		output zero_axis, input ready);
	modport sink (input valid, input m00, input m01, input m02, input m10,
		input m11, input m12, input m20, input m21, input m22,
		input zero_axis, output ready);
endinterface
`default_nettype wire

### hw/rtl/aarm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module aarm_div
	import aarm_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [2*DIV_W-1:0]   num,
	input  logic [DIV_W-1:0]     den,
	output logic [DIV_W-1:0]     quo
);

	logic [DIV_W-1:0] rem_s [DIV_STAGES];
	logic [DIV_W-1:0] lo_s  [DIV_STAGES];
	logic [DIV_W-1:0] den_s [DIV_STAGES];
	logic [DIV_W-1:0] q_s   [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [DIV_W-1:0] ri;
		logic [DIV_W-1:0] li;
		logic [DIV_W-1:0] di;
		logic [DIV_W-1:0] qi;
		logic [DIV_W:0]   tv;
		logic             ge;
		if (i == 0) begin : g_first
			assign ri = num[2*DIV_W-1:DIV_W];
			assign li = num[DIV_W-1:0];
			assign di = den;
			assign qi = '0;
		end else begin : g_next
			assign ri = rem_s[i-1];
			assign li = lo_s[i-1];
			assign di = den_s[i-1];
			assign qi = q_s[i-1];
		end
		assign tv = {ri, li[DIV_W-1]};
		assign ge = tv >= {1'b0, di};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DIV_W'(tv - {1'b0, di}) : tv[DIV_W-1:0];
				lo_s[i]  <= {li[DIV_W-2:0], 1'b0};
				den_s[i] <= di;
				q_s[i]   <= {qi[DIV_W-2:0], ge};
			end
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/aarm_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q30 with quadrant fold.
`default_nettype none
module aarm_cordic
	import aarm_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TRIG_W-1:0] angle,
	input  logic [1:0]               quad,
	output logic signed [TRIG_W-1:0] cosv,
	output logic signed [TRIG_W-1:0] sinv
);

	logic signed [TRIG_W-1:0] x_s [TRIG_STAGES];
	logic signed [TRIG_W-1:0] y_s [TRIG_STAGES];
	logic signed [TRIG_W-1:0] z_s [TRIG_STAGES];
	logic [1:0]               k_s [TRIG_STAGES];
	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
		logic signed [TRIG_W-1:0] xi;
		logic signed [TRIG_W-1:0] yi;
		logic signed [TRIG_W-1:0] zi;
		logic [1:0]               ki;
		if (i == 0) begin : g_first
			assign xi = INV_GAIN_Q30;
			assign yi = '0;
			assign zi = angle;
			assign ki = quad;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ki = k_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_q30(i);
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_q30(i);
				end
				k_s[i] <= ki;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (k_s[TRIG_STAGES-1])
				2'd0: begin
					cos_q <= x_s[TRIG_STAGES-1];
					sin_q <= y_s[TRIG_STAGES-1];
				end
				2'd1: begin
					cos_q <= -y_s[TRIG_STAGES-1];
					sin_q <= x_s[TRIG_STAGES-1];
				end
				2'd2: begin
					cos_q <= -x_s[TRIG_STAGES-1];
					sin_q <= -y_s[TRIG_STAGES-1];
				end
				default: begin
					cos_q <= y_s[TRIG_STAGES-1];
					sin_q <= -x_s[TRIG_STAGES-1];
				end
			endcase
		end
	end

	assign cosv = cos_q;
	assign sinv = sin_q;

endmodule
`default_nettype wire

### hw/rtl/axis_angle_rotation_matrix_core.sv
// Top level of the axis-angle to 3x3 rotation matrix core (Rodrigues' formula).
//
// Each request word carries an axis (Q4.12, any nonzero length) and an angle in
// degrees (Q10.6); each result word carries the nine matrix entries in row-major
// order with ENTRY_FRAC_BITS fraction bits, plus a flag for an all-zero axis, in
// which case the matrix is cos times identity. One word is accepted per cycle while
// the result side does not stall; the depth is set by the 32-stage square root of
// the axis length, then the 32-stage quotient dividers; the angle runs through a
// 16-stage CORDIC in parallel. A stall on the result side holds the whole pipeline.
`default_nettype none
module axis_angle_rotation_matrix_core
	import aarm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	aarm_in_if.sink    req,
	aarm_out_if.source rsp
);

	logic en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en = !vld_q[PIPE_DEPTH-1] || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], req.valid};
		end
	end

	logic signed [15:0] ax_s1 [3];
	logic signed [15:0] ang_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1[0] <= req.axis_x;
			ax_s1[1] <= req.axis_y;
			ax_s1[2] <= req.axis_z;
			ang_s1   <= req.angle_deg;
		end
	end

	logic signed [31:0] pr_s2 [6];
	logic signed [15:0] ax_s2 [3];
	logic signed [17:0] t_raw;
	logic signed [17:0] t_adj;
	logic [14:0]        t_red;
	logic [14:0]        base;
	logic [1:0]         k_c;
	logic signed [15:0] dv;
	logic [1:0]         k_s2;
	logic [11:0]        dmag_s2;
	logic               dneg_s2;

	always_comb begin
		t_raw = 18'(ang_s1) + EIGHTH_UNITS;
		priority if (t_raw < -TURN_UNITS) begin
			t_adj = t_raw + TWO_TURN_UNITS;
		end else if (t_raw < 0) begin
			t_adj = t_raw + TURN_UNITS;
		end else if (t_raw >= TURN_UNITS) begin
			t_adj = t_raw - TURN_UNITS;
		end else begin
			t_adj = t_raw;
		end
		t_red = t_adj[14:0];
		priority if (t_red >= QUARTER_3) begin
			k_c = 2'd3;
			base = QUARTER_3;
		end else if (t_red >= QUARTER_2) begin
			k_c = 2'd2;
			base = QUARTER_2;
		end else if (t_red >= QUARTER_1) begin
			k_c = 2'd1;
			base = QUARTER_1;
		end else begin
			k_c = 2'd0;
			base = '0;
		end
		dv = $signed({1'b0, t_red}) - $signed({1'b0, base}) - 16'sd2880;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2[0] <= ax_s1[0] * ax_s1[0];
			pr_s2[1] <= ax_s1[1] * ax_s1[1];
			pr_s2[2] <= ax_s1[2] * ax_s1[2];
			pr_s2[3] <= ax_s1[0] * ax_s1[1];
			pr_s2[4] <= ax_s1[0] * ax_s1[2];
			pr_s2[5] <= ax_s1[1] * ax_s1[2];
			ax_s2    <= ax_s1;
			k_s2     <= k_c;
			dneg_s2  <= dv < 0;
			dmag_s2  <= (dv < 0) ? 12'(-dv) : 12'(dv);
		end
	end

	axis_t       axb_s3;
	logic [1:0]  k_s3;
	logic        dneg_s3;
	logic [30:0] p1_s3;
	logic [24:0] x2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			axb_s3.a[0] <= ax_s2[0];
			axb_s3.a[1] <= ax_s2[1];
			axb_s3.a[2] <= ax_s2[2];
			for (int j = 0; j < 6; j++) begin
				axb_s3.pr[j] <= pr_s2[j];
			end
			axb_s3.len  <= pr_s2[0][31:0] + pr_s2[1][31:0] + pr_s2[2][31:0];
			axb_s3.zero <= (ax_s2[0] == '0) && (ax_s2[1] == '0) && (ax_s2[2] == '0);
			k_s3    <= k_s2;
			dneg_s3 <= dneg_s2;
			p1_s3   <= 31'(dmag_s2 * PI_DIV_INT);
			x2_s3   <= 25'(dmag_s2 * PI_DIV_REM) + HALF_11520;
		end
	end

	logic [1:0]  k_s4;
	logic        dneg_s4;
	logic [30:0] p1_s4;
	logic [35:0] qp_s4;
	logic [30:0] zmag;
	logic [1:0]  k_s5;
	logic signed [TRIG_W-1:0] z_s5;

	assign zmag = p1_s4 + 31'(qp_s4[35:24]);

	always_ff @(posedge clk) begin
		if (en) begin
			k_s4    <= k_s3;
			dneg_s4 <= dneg_s3;
			p1_s4   <= p1_s3;
			qp_s4   <= 36'(x2_s3[24:8] * RECIP_45);
			k_s5    <= k_s4;
			z_s5    <= dneg_s4 ? -$signed(TRIG_W'(zmag)) : $signed(TRIG_W'(zmag));
		end
	end

	logic signed [TRIG_W-1:0] cos_cd;
	logic signed [TRIG_W-1:0] sin_cd;
	logic signed [TRIG_W-1:0] cdl_s [CS_DELAY];
	logic signed [TRIG_W-1:0] sdl_s [CS_DELAY];

	aarm_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (z_s5),
		.quad  (k_s5),
		.cosv  (cos_cd),
		.sinv  (sin_cd)
	);

	for (genvar k = 0; k < CS_DELAY; k++) begin : g_csdl
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					cdl_s[k] <= cos_cd;
					sdl_s[k] <= sin_cd;
				end else begin
					cdl_s[k] <= cdl_s[k == 0 ? 0 : k-1];
					sdl_s[k] <= sdl_s[k == 0 ? 0 : k-1];
				end
			end
		end
	end

	sqrt_t sq_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		sqrt_t       cur;
		logic [63:0] rad;
		logic [35:0] tv;
		logic [35:0] trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign cur = '{rem: '0, root: '0, ax: axb_s3};
		end else begin : g_next
			assign cur = sq_s[k-1];
		end
		assign rad   = {cur.ax.len, 32'h0};
		assign tv    = {cur.rem, rad[63-2*k -: 2]};
		assign trial = {2'b00, cur.root, 2'b01};
		assign ge    = tv >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k].ax   <= cur.ax;
				sq_s[k].root <= {cur.root[30:0], ge};
				sq_s[k].rem  <= ge ? 34'(tv - trial) : tv[33:0];
			end
		end
	end

	axis_t       axr;
	logic [31:0] root;
	logic [63:0] num_s36 [9];
	logic [31:0] den_s36 [9];
	logic [8:0]  neg_s36;
	logic        zero_s36;

	assign axr  = sq_s[SQRT_STAGES-1].ax;
	assign root = sq_s[SQRT_STAGES-1].root;

	for (genvar j = 0; j < 6; j++) begin : g_pnum
		logic signed [31:0] pv;
		logic [31:0]        pm;
		assign pv = $signed(axr.pr[j]);
		assign pm = (pv < 0) ? 32'(-pv) : 32'(pv);
		always_ff @(posedge clk) begin
			if (en) begin
				num_s36[j] <= 64'({pm, 30'h0}) + 64'(axr.len[31:1]);
				den_s36[j] <= axr.len;
				neg_s36[j] <= pv < 0;
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_nnum
		logic signed [15:0] av;
		logic [15:0]        am;
		assign av = $signed(axr.a[j]);
		assign am = (av < 0) ? 16'(-av) : 16'(av);
		always_ff @(posedge clk) begin
			if (en) begin
				num_s36[6+j] <= 64'({am, 46'h0}) + 64'(root[31:1]);
				den_s36[6+j] <= root;
				neg_s36[6+j] <= av < 0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s36 <= axr.zero;
		end
	end

	logic [DIV_W-1:0] quo [9];
	logic [9:0]       tag_s [DIV_STAGES];

	for (genvar j = 0; j < 9; j++) begin : g_div
		aarm_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s36[j]),
			.den (den_s36[j]),
			.quo (quo[j])
		);
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_tag
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					tag_s[k] <= {zero_s36, neg_s36};
				end else begin
					tag_s[k] <= tag_s[k == 0 ? 0 : k-1];
				end
			end
		end
	end

	logic signed [32:0] val_s69 [9];
	logic               zero_s69;
	logic [9:0]         tag_end;

	assign tag_end = tag_s[DIV_STAGES-1];

	for (genvar j = 0; j < 9; j++) begin : g_val
		always_ff @(posedge clk) begin
			if (en) begin
				if (tag_end[9]) begin
					val_s69[j] <= '0;
				end else if (tag_end[j]) begin
					val_s69[j] <= -$signed({1'b0, quo[j]});
				end else begin
					val_s69[j] <= $signed({1'b0, quo[j]});
				end
			end
		end
	end

	logic signed [TRIG_W-1:0] c69;
	logic signed [TRIG_W-1:0] s69;
	logic signed [TRIG_W:0]   omc;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s69 <= tag_end[9];
		end
	end

	assign c69 = cdl_s[CS_DELAY-1];
	assign s69 = sdl_s[CS_DELAY-1];
	assign omc = (TRIG_W+1)'(ONE_Q30) - (TRIG_W+1)'(c69);

	logic signed [67:0]      mp_s70 [6];
	logic signed [66:0]      sn_s70 [3];
	logic signed [ACC_W-1:0] cd_s70;
	logic                    zero_s70;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				mp_s70[j] <= omc * val_s69[j];
			end
			for (int j = 0; j < 3; j++) begin
				sn_s70[j] <= s69 * val_s69[6+j];
			end
			cd_s70   <= ACC_W'(c69) <<< 30;
			zero_s70 <= zero_s69;
		end
	end

	logic signed [ACC_W-1:0] acc_s71 [9];
	logic                    zero_s71;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s71[0] <= cd_s70 + mp_s70[0] + ROUND_HALF;
			acc_s71[1] <= mp_s70[3] - sn_s70[2] + ROUND_HALF;
			acc_s71[2] <= mp_s70[4] + sn_s70[1] + ROUND_HALF;
			acc_s71[3] <= mp_s70[3] + sn_s70[2] + ROUND_HALF;
			acc_s71[4] <= cd_s70 + mp_s70[1] + ROUND_HALF;
			acc_s71[5] <= mp_s70[5] - sn_s70[0] + ROUND_HALF;
			acc_s71[6] <= mp_s70[4] - sn_s70[1] + ROUND_HALF;
			acc_s71[7] <= mp_s70[5] + sn_s70[0] + ROUND_HALF;
			acc_s71[8] <= cd_s70 + mp_s70[2] + ROUND_HALF;
			zero_s71   <= zero_s70;
		end
	end

	logic signed [15:0] m_s72 [9];
	logic               zero_s72;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				m_s72[j] <= sat_entry(acc_s71[j]);
			end
			zero_s72 <= zero_s71;
		end
	end

	assign rsp.m00       = m_s72[0];
	assign rsp.m01       = m_s72[1];
	assign rsp.m02       = m_s72[2];
	assign rsp.m10       = m_s72[3];
	assign rsp.m11       = m_s72[4];
	assign rsp.m12       = m_s72[5];
	assign rsp.m20       = m_s72[6];
	assign rsp.m21       = m_s72[7];
	assign rsp.m22       = m_s72[8];
	assign rsp.zero_axis = zero_s72;

	// A zero axis leaves only cos on the diagonal.
	a_zero_offdiag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.zero_axis |-> rsp.m01 == 16'sd0 && rsp.m02 == 16'sd0 &&
			rsp.m10 == 16'sd0 && rsp.m12 == 16'sd0 && rsp.m20 == 16'sd0 &&
			rsp.m21 == 16'sd0)
		else $error("zero axis word has a nonzero off-diagonal entry");

	a_zero_diag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.zero_axis |-> rsp.m00 == rsp.m11 && rsp.m11 == rsp.m22)
		else $error("zero axis word has unequal diagonal entries");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request side stalled while the result register is empty");

	a_stall_holds_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |=> rsp.valid)
		else $error("result word lost during a stall");

endmodule
`default_nettype wire

### tb/axis_angle_rotation_matrix_core_tb.sv
// Testbench for the rotation matrix core: random and directed words checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_rotation_matrix_core_tb;
	import aarm_pkg::*;

	typedef struct packed {
		logic signed [15:0] ax, ay, az, ang;
	} request_t;

	typedef struct packed {
		logic [8:0][15:0] m;
		logic             zero;
	} matrix_t;

	localparam longint PI_Q30_L = 64'd3373259426;
	localparam longint INV_GAIN_L = 64'd652032874;
	localparam longint ONE_L = 64'd1073741824;
	localparam int ATAN_TAB [13] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144};

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rdiv(longint num, longint den);
		longint mag, q;
		if (den <= 0) return 0;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint root64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint entry_of(longint acc);
		int sh;
		longint v;
		sh = 60 - ENTRY_FRAC_BITS;
		v = fshr(acc + (longint'(1) << (sh - 1)), sh);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	function automatic matrix_t rotation_of(request_t r);
		longint a [3], n [3], cr [3][3];
		longint rem, t, k, d, x, y, z, dx, dy, c, s, len2, rt, acc, st;
		matrix_t res;
		rem = longint'(r.ang) % 23040;
		if (rem < 0) rem += 23040;
		t = rem + 2880;
		if (t >= 23040) t -= 23040;
		k = t / 5760;
		d = t - k * 5760 - 2880;
		z = rdiv(d * PI_Q30_L, 11520);
		x = INV_GAIN_L;
		y = 0;
		for (int i = 0; i < TRIG_STAGES; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			st = i < 13 ? ATAN_TAB[i] : (i <= 30 ? longint'(1) << (30 - i) : 0);
			if (z >= 0) begin
				x -= dx; y += dy; z -= st;
			end else begin
				x += dx; y -= dy; z += st;
			end
		end
		case (k)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		a[0] = longint'(r.ax); a[1] = longint'(r.ay); a[2] = longint'(r.az);
		n = '{0, 0, 0};
		len2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		if (len2 != 0) begin
			rt = root64(longint'(len2) << 32);
			for (int i = 0; i < 3; i++) n[i] = rdiv(a[i] * (longint'(1) << 46), rt);
		end
		cr = '{'{0, -n[2], n[1]}, '{n[2], 0, -n[0]}, '{-n[1], n[0], 0}};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = (i == j) ? c * ONE_L : 0;
				if (len2 != 0)
					acc += (ONE_L - c) * rdiv(a[i] * a[j] * ONE_L, len2) + s * cr[i][j];
				res.m[8 - (i * 3 + j)] = 16'(entry_of(acc));
			end
		end
		res.zero = (len2 == 0);
		return res;
	endfunction

	class matrix_scoreboard;
		matrix_t pending [$];
		int errors = 0;

		function void note_request(request_t r);
			pending.push_back(rotation_of(r));
		endfunction

		function void check_result(matrix_t got);
			matrix_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 9; i++) begin
				if (got.m[8 - i] !== want.m[8 - i]) begin
					errors++;
					if (errors <= 10)
						$display("m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
							$signed(want.m[8 - i]), $signed(got.m[8 - i]));
				end
			end
			if (got.zero !== want.zero) begin
				errors++;
				if (errors <= 10)
					$display("zero_axis: expected %b, got %b", want.zero, got.zero);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	aarm_in_if req ();
	aarm_out_if rsp ();
	matrix_scoreboard sb = new();
	longint cycles = 0;
	bit hold_off = 0;
	bit stall_mode = 0;

	axis_angle_rotation_matrix_core u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("axis_angle_rotation_matrix_core_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			sb.note_request({req.axis_x, req.axis_y, req.axis_z, req.angle_deg});
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result({rsp.m00, rsp.m01, rsp.m02, rsp.m10, rsp.m11, rsp.m12,
				rsp.m20, rsp.m21, rsp.m22, rsp.zero_axis});
	end

	initial begin
		rsp.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) rsp.ready <= 0;
			else if (!stall_mode) rsp.ready <= 1;
			else rsp.ready <= (cycles % 7 < 4) ^ ($urandom_range(0, 5) == 0);
		end
	end

	task automatic send(request_t r);
		req.valid <= 1;
		req.axis_x <= r.ax;
		req.axis_y <= r.ay;
		req.axis_z <= r.az;
		req.angle_deg <= r.ang;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic idle(int n);
		req.valid <= 0;
		req.axis_x <= 16'($urandom);
		repeat (n) @(negedge clk);
	endtask

	function automatic request_t random_request();
		request_t r;
		int sel;
		r = {32'($urandom), 32'($urandom)};
		sel = $urandom_range(0, 9);
		if (sel == 0) {r.ax, r.ay, r.az} = '0;
		else if (sel < 4) begin
			r.ax = 16'(int'($urandom_range(0, 8192)) - 4096);
			r.ay = 16'(int'($urandom_range(0, 8192)) - 4096);
			r.az = 16'(int'($urandom_range(0, 8192)) - 4096);
		end else if (sel == 4) begin
			r.ax = 16'(int'($urandom_range(0, 2)) - 1);
			r.ay = '0;
			r.az = 16'($urandom_range(0, 1));
		end
		if (sel == 5) r.ang = 16'(int'($urandom_range(0, 46080)) - 23040);
		return r;
	endfunction

	initial begin
		request_t dir [$];
		req.valid = 0;
		req.axis_x = 0; req.axis_y = 0; req.axis_z = 0; req.angle_deg = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		dir = '{
			'{16'sh1000, 0, 0, 16'sd5760}, '{0, 16'sh1000, 0, 16'sd5760},
			'{0, 0, 16'sh1000, 16'sd5760}, '{0, 0, 0, 16'sd2880},
			'{0, 0, 0, 16'sh8000}, '{0, 0, 0, 16'sh7FFF},
			'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd11520},
			'{16'sh8000, 16'sh8000, 16'sh8000, -16'sd5760},
			'{16'sh8000, 16'sh7FFF, 0, 16'sd23040}, '{1, 0, 0, 16'sd2879},
			'{-1, -1, -1, 16'sd2880}, '{0, 1, 0, -16'sd2880},
			'{16'sh1000, 16'sh1000, 16'sh1000, 16'sd7680},
			'{16'sh0400, -16'sh0800, 16'sh0C00, 16'sd17280},
			'{16'sh0001, 16'sh7FFF, 16'sh8000, 16'sd0},
			'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA},
			'{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555},
			'{16'sh1000, 0, 0, -16'sd23040}, '{0, 0, 16'sh1000, 16'sd8640}};
		foreach (dir[i]) send(dir[i]);
		idle(1);
		stall_mode = 1;
		for (int i = 0; i < 380; i++) begin
			if (i == 60) begin
				hold_off = 1;
				fork
					begin
						repeat (200) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (i == 150) begin
				idle(1);
				while (sb.pending.size() != 0) @(negedge clk);
			end
			if (i == 200) stall_mode = 0;
			if (i == 280) stall_mode = 1;
			send(random_request());
			if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 6));
		end
		idle(1);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("axis_angle_rotation_matrix_core_tb: clean");
		else
			$display("axis_angle_rotation_matrix_core_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/aarm_pkg.sv
hw/rtl/aarm_if.sv
hw/rtl/aarm_div.sv
hw/rtl/aarm_cordic.sv
hw/rtl/axis_angle_rotation_matrix_core.sv
tb/axis_angle_rotation_matrix_core_tb.sv
